// ===== rtl/core/pdl_pkg.sv =====
// Package: shared types and constants for the paddle controller serial port.
package pdl_pkg;

   localparam int POS_W  = 12;
   localparam int BTN_W  = 4;
   localparam int DATA_W = 5;
   localparam int KNOB_W = 8;
   localparam int PROD_W = 27;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   localparam logic [KNOB_W-1:0] KNOB_MIN     = 8'd32;
   localparam logic [KNOB_W-1:0] KNOB_MAX     = 8'd176;
   localparam logic [KNOB_W-1:0] SCALE_OFFSET = 8'd82;
   localparam logic [KNOB_W-1:0] SCALE_TOP    = 8'hFF;
   // floor(x*172/144) == (x * 313126) >> 18 for x in 0..144
   localparam logic [PROD_W-1:0] SCALE_RECIP  = 27'd313126;
   localparam int                RECIP_SHIFT  = 18;

   localparam logic [BTN_W-1:0] STD_BTN = 4'h8;
   localparam logic [BTN_W-1:0] EXP_BTN = 4'h2;
   localparam logic [POS_W-1:0] STD_DATA_MASK = 12'h010;
   localparam logic [POS_W-1:0] EXP_DATA_MASK = 12'h002;

   typedef struct packed {
      logic              func;
      logic              read_port;
      logic [KNOB_W-1:0] write_value;
      logic              sample_valid;
      logic [KNOB_W-1:0] knob_position;
      logic              button_pressed;
   } pdl_req_type;

endpackage

// ===== rtl/core/pdl_ifs.sv =====
// Interfaces: request and response channels of the paddle controller.
interface pdl_req_if;
   import pdl_pkg::*;
   logic              valid;
   logic              ready;
   logic              func;
   logic              read_port;
   logic [KNOB_W-1:0] write_value;
   logic              sample_valid;
   logic [KNOB_W-1:0] knob_position;
   logic              button_pressed;

   modport source (output valid, func, read_port, write_value, sample_valid,
                   knob_position, button_pressed, input ready);
   modport sink (input valid, func, read_port, write_value, sample_valid,
                 knob_position, button_pressed, output ready);
endinterface

interface pdl_rsp_if;
   import pdl_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink (input valid, read_data, output ready);
endinterface

// ===== rtl/core/pdl_knob_conv.sv =====
// Knob conversion: clamp, scale, invert, bit-reverse and align the position code.
module pdl_knob_conv
   import pdl_pkg::*;
(
   input  logic [KNOB_W-1:0] knob_position,
   input  logic              expansion_mode,
   output logic [POS_W-1:0]  pos_code
);

   logic [KNOB_W-1:0] clamped;
   logic [KNOB_W-1:0] offset;
   logic [PROD_W-1:0] prod;
   logic [KNOB_W-1:0] quot;
   logic [KNOB_W-1:0] scaled;
   logic [KNOB_W-1:0] rev;

   always_comb begin
      if (knob_position < KNOB_MIN) begin
         clamped = KNOB_MIN;
      end else if (knob_position > KNOB_MAX) begin
         clamped = KNOB_MAX;
      end else begin
         clamped = knob_position;
      end
      offset = clamped - KNOB_MIN;
      prod   = PROD_W'(offset) * SCALE_RECIP;
      quot   = prod[RECIP_SHIFT +: KNOB_W];
      scaled = SCALE_TOP - (SCALE_OFFSET + quot);
      for (int i = 0; i < KNOB_W; i++) begin
         rev[i] = scaled[KNOB_W-1-i];
      end
      if (expansion_mode) begin
         pos_code = POS_W'(rev) << 1;
      end else begin
         pos_code = POS_W'(rev) << 4;
      end
   end

endmodule

// ===== rtl/core/pdl_port_state.sv =====
// Port state: strobe, held sample, shift and button registers, read data.
module pdl_port_state
   import pdl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  pdl_req_type       req,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   output logic [DATA_W-1:0] result
);

   logic             mode_ff, mode_in;
   logic             shift_en_ff, shift_en_in;
   logic [POS_W-1:0] pos_shift_ff, pos_shift_in;
   logic [BTN_W-1:0] btn_ff, btn_in;
   logic [POS_W-1:0] held_pos_ff, held_pos_in;
   logic [BTN_W-1:0] held_btn_ff, held_btn_in;
   logic [POS_W-1:0] new_code;
   logic             release_strobe;

   pdl_knob_conv u_conv (
      .knob_position  (req.knob_position),
      .expansion_mode (mode_ff),
      .pos_code       (new_code)
   );

   assign release_strobe = !shift_en_ff && !req.write_value[0];

   always_comb begin
      mode_in      = csr_wr_en ? csr_wr_data : mode_ff;
      shift_en_in  = shift_en_ff;
      pos_shift_in = pos_shift_ff;
      btn_in       = btn_ff;
      held_pos_in  = held_pos_ff;
      held_btn_in  = held_btn_ff;
      result       = '0;
      if (accept) begin
         if (req.func == FUNC_WRITE) begin
            shift_en_in = !req.write_value[0];
            if (release_strobe) begin
               if (req.sample_valid) begin
                  held_pos_in = new_code;
                  held_btn_in = req.button_pressed ? (mode_ff ? EXP_BTN : STD_BTN) : '0;
               end
               pos_shift_in = held_pos_in;
               btn_in       = held_btn_in;
            end
         end else if (!mode_ff) begin
            pos_shift_in = pos_shift_ff >> shift_en_ff;
            result = DATA_W'(pos_shift_ff & STD_DATA_MASK) | DATA_W'(btn_ff);
         end else if (req.read_port) begin
            pos_shift_in = pos_shift_ff >> shift_en_ff;
            result = DATA_W'(pos_shift_ff & EXP_DATA_MASK);
         end else begin
            result = DATA_W'(btn_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         shift_en_ff  <= 1'b1;
         pos_shift_ff <= '0;
         btn_ff       <= '0;
         held_pos_ff  <= '0;
         held_btn_ff  <= '0;
      end else begin
         mode_ff      <= mode_in;
         shift_en_ff  <= shift_en_in;
         pos_shift_ff <= pos_shift_in;
         btn_ff       <= btn_in;
         held_pos_ff  <= held_pos_in;
         held_btn_ff  <= held_btn_in;
      end
   end

endmodule

// ===== rtl/core/paddle_controller_serial_port.sv =====
// Top level: paddle controller serial port with registered response.
// Latency: a response is valid the cycle after its request transaction.
// Throughput: one transaction per cycle; the response register lets a new
// request in whenever it is empty or being drained in the same cycle.
// Reset: synchronous, clears the response valid flag (not its data), mode and port state
// (strobe released, shift and held registers zero).
module paddle_controller_serial_port
   import pdl_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   pdl_req_if.sink   req_chan,
   pdl_rsp_if.source rsp_chan,
   input  logic   csr_wr_en,
   input  logic   csr_wr_data
);

   pdl_req_type       req;
   logic              accept;
   logic [DATA_W-1:0] result;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign req = '{func: req_chan.func, read_port: req_chan.read_port,
                  write_value: req_chan.write_value, sample_valid: req_chan.sample_valid,
                  knob_position: req_chan.knob_position,
                  button_pressed: req_chan.button_pressed};

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   pdl_port_state u_state (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;

`ifndef SYNTHESIS
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction did not produce a response");

   a_write_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && req.func == FUNC_WRITE) |=> (rsp_data_ff == '0))
      else $error("write transaction returned nonzero data");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while response stalled");
`endif

endmodule

// ===== bench/tb.sv =====
// Testbench for the paddle controller serial port: predicted read data checked per transaction.
module tb;
   import pdl_pkg::*;

   localparam logic MODE_STD     = 1'b0;
   localparam logic MODE_EXP     = 1'b1;
   localparam logic PORT_BUTTONS = 1'b0;
   localparam logic PORT_DATA    = 1'b1;
   localparam int   IDLE_PCT     = 34;
   localparam int   HOLD_CYCLES  = 300;
   localparam int   DRAIN_CYCLES = 4;
   localparam int   CYCLE_LIMIT  = 100000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic csr_wr_data;

   pdl_req_if req_if ();
   pdl_rsp_if rsp_if ();

   paddle_controller_serial_port u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // port model
   logic              mode_now   = MODE_STD;
   logic [POS_W-1:0]  shift_reg  = '0;
   logic [BTN_W-1:0]  button_reg = '0;
   logic              shifting   = 1'b1;
   logic [POS_W-1:0]  held_code  = '0;
   logic [BTN_W-1:0]  held_btn   = '0;

   pdl_req_type       pending_q[$];
   logic [DATA_W-1:0] read_data_q[$];
   int                fail_count = 0;
   int                cycle_count = 0;
   bit                quiet = 1'b0;
   bit                hold_req = 1'b0;
   bit                hold_taken = 1'b0;
   int                hold_left = 0;

   function automatic logic [POS_W-1:0] knob_to_code(logic [KNOB_W-1:0] knob, logic mode);
      int               p;
      int               scaled;
      int               i;
      logic [7:0]       s;
      logic [7:0]       r;
      p = int'(knob);
      if (p < 32) p = 32;
      if (p > 176) p = 176;
      scaled = 255 - ((82 + 172 * (p - 32) / 144) & 255);
      s = scaled[7:0];
      for (i = 0; i < 8; i++) r[i] = s[7-i];
      return (mode == MODE_EXP) ? {3'b000, r, 1'b0} : {r, 4'b0000};
   endfunction

   function automatic logic [DATA_W-1:0] port_access(pdl_req_type t);
      logic             was_shifting;
      logic [POS_W-1:0] cur;
      cur = shift_reg;
      if (t.func == FUNC_WRITE) begin
         was_shifting = shifting;
         shifting = ~t.write_value[0];
         if (!was_shifting && shifting) begin
            if (t.sample_valid) begin
               held_code = knob_to_code(t.knob_position, mode_now);
               held_btn = t.button_pressed ? ((mode_now == MODE_EXP) ? 4'h2 : 4'h8) : 4'h0;
            end
            shift_reg = held_code;
            button_reg = held_btn;
         end
         return '0;
      end
      if (mode_now == MODE_STD) begin
         if (shifting) shift_reg = shift_reg >> 1;
         return {cur[4], button_reg};
      end
      if (t.read_port == PORT_DATA) begin
         if (shifting) shift_reg = shift_reg >> 1;
         return {3'b000, cur[1], 1'b0};
      end
      return {1'b0, button_reg};
   endfunction

   // request driver
   always @(posedge clock) begin : drive
      pdl_req_type sent;
      pdl_req_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            sent = '{func: req_if.func, read_port: req_if.read_port,
                     write_value: req_if.write_value, sample_valid: req_if.sample_valid,
                     knob_position: req_if.knob_position,
                     button_pressed: req_if.button_pressed};
            read_data_q.push_back(port_access(sent));
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
               nxt = pending_q.pop_front();
               req_if.valid          <= 1'b1;
               req_if.func           <= nxt.func;
               req_if.read_port      <= nxt.read_port;
               req_if.write_value    <= nxt.write_value;
               req_if.sample_valid   <= nxt.sample_valid;
               req_if.knob_position  <= nxt.knob_position;
               req_if.button_pressed <= nxt.button_pressed;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : observe
      logic [DATA_W-1:0] want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (read_data_q.size() == 0) begin
               $error("read_data: unexpected transaction, actual %0h", rsp_if.read_data);
               fail_count++;
            end else begin
               want = read_data_q.pop_front();
               if (want !== rsp_if.read_data) begin
                  $error("read_data: expected %0h actual %0h", want, rsp_if.read_data);
                  fail_count++;
               end
            end
         end
         if (hold_req && !hold_taken) begin
            hold_left = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   task automatic queue_access(logic func, logic port, logic [7:0] wval, logic sv,
                               logic [7:0] knob, logic btn);
      pending_q.push_back('{func: func, read_port: port, write_value: wval,
                            sample_valid: sv, knob_position: knob, button_pressed: btn});
   endtask

   task automatic wait_drain();
      @(negedge clock);
      while (pending_q.size() != 0 || read_data_q.size() != 0 || req_if.valid)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_mode(logic mode);
      wait_drain();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      mode_now = mode;
   endtask

   function automatic logic [7:0] pick_knob();
      logic [7:0] edges[8] = '{8'd0, 8'd31, 8'd32, 8'd33, 8'd175, 8'd176, 8'd177, 8'd255};
      if ($urandom_range(3) == 0) return edges[3'($urandom_range(7))];
      return 8'($urandom_range(255));
   endfunction

   // strobe, release usually with a sample, then a burst of reads; mixed with raw noise
   task automatic queue_random(int count);
      int n;
      int reads;
      int i;
      n = 0;
      while (n < count) begin
         if ($urandom_range(4) != 0) begin
            queue_access(FUNC_WRITE, 1'($urandom_range(1)), {7'($urandom_range(127)), 1'b1},
                         1'($urandom_range(1)), 8'($urandom_range(255)),
                         1'($urandom_range(1)));
            queue_access(FUNC_WRITE, 1'($urandom_range(1)), {7'($urandom_range(127)), 1'b0},
                         $urandom_range(9) != 0, pick_knob(), 1'($urandom_range(1)));
            reads = $urandom_range(14, 1);
            for (i = 0; i < reads; i++)
               queue_access(FUNC_READ, 1'($urandom_range(1)), 8'($urandom_range(255)),
                            1'($urandom_range(1)), 8'($urandom_range(255)),
                            1'($urandom_range(1)));
            n += reads + 2;
         end else begin
            reads = $urandom_range(4, 1);
            for (i = 0; i < reads; i++)
               queue_access(1'($urandom_range(1)), 1'($urandom_range(1)),
                            8'($urandom_range(255)), 1'($urandom_range(1)),
                            8'($urandom_range(255)), 1'($urandom_range(1)));
            n += reads;
         end
      end
   endtask

   initial begin
      csr_wr_en             = 1'b0;
      csr_wr_data           = 1'b0;
      req_if.valid          = 1'b0;
      req_if.func           = FUNC_READ;
      req_if.read_port      = PORT_BUTTONS;
      req_if.write_value    = '0;
      req_if.sample_valid   = 1'b0;
      req_if.knob_position  = '0;
      req_if.button_pressed = 1'b0;
      rsp_if.ready          = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      set_mode(MODE_STD);
      queue_access(FUNC_READ,  PORT_DATA,    8'h00, 1'b0, 8'd0,   1'b0);
      // sample while the strobe is held is ignored
      queue_access(FUNC_WRITE, PORT_BUTTONS, 8'hFF, 1'b1, 8'd200, 1'b1);
      queue_access(FUNC_WRITE, PORT_DATA,    8'hFE, 1'b1, 8'd0,   1'b1);
      queue_access(FUNC_READ,  PORT_BUTTONS, 8'h00, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_READ,  PORT_DATA,    8'hAA, 1'b1, 8'd255, 1'b1);
      queue_access(FUNC_READ,  PORT_BUTTONS, 8'h55, 1'b0, 8'd0,   1'b0);
      // release with no sample reloads held values
      queue_access(FUNC_WRITE, PORT_BUTTONS, 8'h01, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_WRITE, PORT_BUTTONS, 8'h00, 1'b0, 8'd255, 1'b1);
      queue_access(FUNC_READ,  PORT_BUTTONS, 8'h00, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_READ,  PORT_BUTTONS, 8'h00, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_WRITE, PORT_BUTTONS, 8'h01, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_WRITE, PORT_BUTTONS, 8'h00, 1'b1, 8'd176, 1'b0);
      queue_access(FUNC_READ,  PORT_BUTTONS, 8'h00, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_WRITE, PORT_BUTTONS, 8'h01, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_WRITE, PORT_BUTTONS, 8'h00, 1'b1, 8'd177, 1'b1);
      // reads with the strobe held do not shift
      queue_access(FUNC_WRITE, PORT_BUTTONS, 8'h01, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_READ,  PORT_BUTTONS, 8'h00, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_READ,  PORT_BUTTONS, 8'h00, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_WRITE, PORT_BUTTONS, 8'h00, 1'b1, 8'd32,  1'b0);
      queue_access(FUNC_WRITE, PORT_BUTTONS, 8'h00, 1'b1, 8'd100, 1'b1);
      queue_access(FUNC_READ,  PORT_BUTTONS, 8'h00, 1'b0, 8'd0,   1'b0);

      // held values keep the standard layout after the switch
      set_mode(MODE_EXP);
      queue_access(FUNC_WRITE, PORT_DATA,    8'h01, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_WRITE, PORT_DATA,    8'h00, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_READ,  PORT_DATA,    8'h00, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_READ,  PORT_BUTTONS, 8'h00, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_WRITE, PORT_DATA,    8'h01, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_WRITE, PORT_DATA,    8'h00, 1'b1, 8'd31,  1'b1);
      queue_access(FUNC_READ,  PORT_BUTTONS, 8'h00, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_READ,  PORT_DATA,    8'h00, 1'b0, 8'd0,   1'b0);
      queue_access(FUNC_READ,  PORT_DATA,    8'h00, 1'b0, 8'd0,   1'b0);

      set_mode(MODE_STD);
      quiet = 1'b1;
      queue_random(400);
      while (pending_q.size() > 250) @(negedge clock);
      quiet = 1'b0;
      while (pending_q.size() > 150) @(negedge clock);
      hold_req = 1'b1;

      set_mode(MODE_EXP);
      queue_random(400);

      set_mode(MODE_STD);
      queue_random(420);

      wait_drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && read_data_q.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/pdl_pkg.sv
rtl/core/pdl_ifs.sv
rtl/core/pdl_knob_conv.sv
rtl/core/pdl_port_state.sv
rtl/core/paddle_controller_serial_port.sv
bench/tb.sv
